// ===== sv/depth_pixel_to_point_backprojection_defines.svh =====
// assertion macros shared by the rtl files
`ifndef DEPTH_PIXEL_TO_POINT_BACKPROJECTION_DEFINES_SVH
`define DEPTH_PIXEL_TO_POINT_BACKPROJECTION_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define DPB_ASSERT_HOLDS(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define DPB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/dpb_pkg.sv =====
package dpb_pkg;

    // configuration register file
    typedef struct packed {
        logic [12:0] frame_width;
        logic [12:0] frame_height;
        logic [12:0] center_x_half;
        logic [12:0] center_y_half;
        logic [23:0] inv_focal_x;
        logic [23:0] inv_focal_y;
        logic [31:0] inv_depth_scale;
    } cfg_t;

    // apb address layout
    localparam int ADDR_W = 5;

    typedef logic [2:0] reg_idx_t;

    localparam reg_idx_t REG_FRAME_WIDTH     = 3'd0;
    localparam reg_idx_t REG_FRAME_HEIGHT    = 3'd1;
    localparam reg_idx_t REG_CENTER_X_HALF   = 3'd2;
    localparam reg_idx_t REG_CENTER_Y_HALF   = 3'd3;
    localparam reg_idx_t REG_INV_FOCAL_X     = 3'd4;
    localparam reg_idx_t REG_INV_FOCAL_Y     = 3'd5;
    localparam reg_idx_t REG_INV_DEPTH_SCALE = 3'd6;

    // register reset values
    localparam logic [12:0] RST_FRAME_WIDTH     = 13'd640;
    localparam logic [12:0] RST_FRAME_HEIGHT    = 13'd480;
    localparam logic [12:0] RST_CENTER_X_HALF   = 13'd639;
    localparam logic [12:0] RST_CENTER_Y_HALF   = 13'd479;
    localparam logic [23:0] RST_INV_FOCAL_X     = 24'd31957;
    localparam logic [23:0] RST_INV_FOCAL_Y     = 24'd31957;
    localparam logic [31:0] RST_INV_DEPTH_SCALE = 32'd858993;

    // entries in the queue between front and back end
    localparam int QUEUE_DEPTH = 4;

    // back end sequencer; each step from S_Z to S_MAGY issues a product, captures one, or both
    typedef enum logic [3:0] {
        S_IDLE,
        S_Z,
        S_ZCAP,
        S_QX,
        S_QY,
        S_LOX,
        S_HIX,
        S_LOY,
        S_HIY,
        S_MAGY,
        S_OUT
    } back_state_t;

endpackage

// ===== sv/dpb_fifo.sv =====
`include "depth_pixel_to_point_backprojection_defines.svh"

module dpb_fifo #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             valid
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // status
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign valid    = (count_reg != '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    `DPB_ASSERT_HOLDS(a_fifo_no_overflow, clk, rst_n, push, count_reg != CNT_W'(DEPTH), "write into full queue")
    `DPB_ASSERT_NEXT(a_fifo_count_up, clk, rst_n, push && !pop, count_reg == CNT_W'($past(count_reg) + 1'b1), "queue count did not rise")

endmodule

// ===== sv/dpb_front.sv =====
module dpb_front import dpb_pkg::*; #(
    parameter int COORD_BITS = 12,
    localparam int ENTRY_W = 40 + 2 * COORD_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               push,
    output logic               full,
    input  logic [15:0]        depth_raw,
    input  logic [7:0]         blue,
    input  logic [7:0]         green,
    input  logic [7:0]         red,
    input  logic               fifo_full,
    output logic               fifo_push,
    output logic [ENTRY_W-1:0] fifo_data
);

    localparam int CMP_W = (COORD_BITS + 1 > 13) ? COORD_BITS + 1 : 13;

    logic [COORD_BITS-1:0] col_reg;
    logic [COORD_BITS-1:0] col_next;
    logic [COORD_BITS-1:0] row_reg;
    logic [COORD_BITS-1:0] row_next;
    logic [COORD_BITS:0]   col_inc;
    logic [COORD_BITS:0]   row_inc;
    logic                  col_wrap;
    logic                  row_wrap;
    logic                  accept;

    // a transaction is taken whenever the queue has room
    assign full   = fifo_full;
    assign accept = push && !fifo_full;

    // only pixels with a depth measurement go on to the back end
    assign fifo_push = accept && (depth_raw != 16'd0);
    assign fifo_data = {depth_raw, blue, green, red, col_reg, row_reg};

    // raster position, wrap at frame size or counter range
    always_comb
    begin
        col_inc  = {1'b0, col_reg} + 1'b1;
        row_inc  = {1'b0, row_reg} + 1'b1;
        col_wrap = (CMP_W'(col_inc) >= CMP_W'(cfg.frame_width)) || col_inc[COORD_BITS];
        row_wrap = (CMP_W'(row_inc) >= CMP_W'(cfg.frame_height)) || row_inc[COORD_BITS];
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            col_next = col_wrap ? '0 : col_inc[COORD_BITS-1:0];
            if (col_wrap)
            begin
                row_next = row_wrap ? '0 : row_inc[COORD_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

// ===== sv/dpb_back.sv =====
`include "depth_pixel_to_point_backprojection_defines.svh"

module dpb_back import dpb_pkg::*; #(
    parameter int COORD_BITS = 12,
    localparam int ENTRY_W = 40 + 2 * COORD_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               q_valid,
    input  logic [ENTRY_W-1:0] q_data,
    output logic               q_pop,
    output logic               empty,
    input  logic               pop,
    output logic signed [31:0] point_x,
    output logic signed [31:0] point_y,
    output logic [31:0]        point_z,
    output logic [7:0]         point_blue,
    output logic [7:0]         point_green,
    output logic [7:0]         point_red,
    output logic [11:0]        point_col,
    output logic [11:0]        point_row
);

    localparam int D_W  = (COORD_BITS + 2 > 14) ? COORD_BITS + 2 : 14;
    localparam int M_W  = D_W - 1;
    localparam int LO_W = 24;
    localparam int MAG_W = 48;

    typedef struct packed {
        logic        load;
        logic        cap_z;
        logic        cap_qx;
        logic        cap_qy;
        logic        cap_lo;
        logic        cap_magx;
        logic        cap_magy;
        logic        res_write;
        logic [31:0] op_a;
        logic [31:0] op_b;
    } back_ctl_t;

    back_state_t state_reg;
    back_state_t state_next;
    back_ctl_t   ctl;

    // queue entry fields
    logic [15:0]           q_depth;
    logic [7:0]            q_blue;
    logic [7:0]            q_green;
    logic [7:0]            q_red;
    logic [COORD_BITS-1:0] q_col;
    logic [COORD_BITS-1:0] q_row;

    // working registers
    logic [15:0]      depth_reg;
    logic [7:0]       blue_reg;
    logic [7:0]       green_reg;
    logic [7:0]       red_reg;
    logic [11:0]      col_reg;
    logic [11:0]      row_reg;
    logic             negx_reg;
    logic             negy_reg;
    logic [M_W-1:0]   mx_reg;
    logic [M_W-1:0]   my_reg;
    logic [63:0]      prod_reg;
    logic [31:0]      z_reg;
    logic [31:0]      z_next;
    logic [55:0]      qx_reg;
    logic [55:0]      qy_reg;
    logic [LO_W-1:0]  lo_reg;
    logic [LO_W-1:0]  lo_next;
    logic [MAG_W-1:0] magx_reg;
    logic [MAG_W-1:0] magy_reg;
    logic [MAG_W-1:0] mag_next;

    // offsets from the optical center in half pixels
    logic signed [D_W-1:0] dx;
    logic signed [D_W-1:0] dy;
    logic [D_W-1:0]        dx_abs;
    logic [D_W-1:0]        dy_abs;

    // result register
    logic        res_valid_reg;
    logic        res_valid_next;
    logic [31:0] res_x_reg;
    logic [31:0] res_y_reg;
    logic [31:0] res_z_reg;
    logic [7:0]  res_blue_reg;
    logic [7:0]  res_green_reg;
    logic [7:0]  res_red_reg;
    logic [11:0] res_col_reg;
    logic [11:0] res_row_reg;
    logic        slot_free;

    // saturate a rounded magnitude with its sign to signed q16.16
    function automatic logic [31:0] sat_lateral(input logic neg, input logic [MAG_W-1:0] mag);
        logic [31:0] res;
        if (neg)
        begin
            if (mag >= MAG_W'(32'h8000_0000))
                res = 32'h8000_0000;
            else
                res = ~mag[31:0] + 32'd1;
        end
        else
        begin
            if (mag > MAG_W'(32'h7fff_ffff))
                res = 32'h7fff_ffff;
            else
                res = mag[31:0];
        end
        return res;
    endfunction

    // unpack queue entry
    assign q_depth = q_data[ENTRY_W-1 -: 16];
    assign q_blue  = q_data[2*COORD_BITS+23 -: 8];
    assign q_green = q_data[2*COORD_BITS+15 -: 8];
    assign q_red   = q_data[2*COORD_BITS+7 -: 8];
    assign q_col   = q_data[2*COORD_BITS-1 -: COORD_BITS];
    assign q_row   = q_data[COORD_BITS-1:0];

    // signed offset and its magnitude
    always_comb
    begin
        dx     = $signed(D_W'({q_col, 1'b0})) - $signed(D_W'(cfg.center_x_half));
        dy     = $signed(D_W'({q_row, 1'b0})) - $signed(D_W'(cfg.center_y_half));
        dx_abs = dx[D_W-1] ? (~dx + 1'b1) : dx;
        dy_abs = dy[D_W-1] ? (~dy + 1'b1) : dy;
    end

    assign slot_free = !res_valid_reg || pop;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (q_valid) state_next = S_Z;
            S_Z:    state_next = S_ZCAP;
            S_ZCAP: state_next = S_QX;
            S_QX:   state_next = S_QY;
            S_QY:   state_next = S_LOX;
            S_LOX:  state_next = S_HIX;
            S_HIX:  state_next = S_LOY;
            S_LOY:  state_next = S_HIY;
            S_HIY:  state_next = S_MAGY;
            S_MAGY: state_next = S_OUT;
            S_OUT:  if (slot_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // step controls and multiplier operands
    always_comb
    begin
        ctl = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                ctl.load = q_valid;
            end
            S_Z:
            begin
                ctl.op_a = 32'(depth_reg);
                ctl.op_b = cfg.inv_depth_scale;
            end
            S_ZCAP:
            begin
                ctl.cap_z = 1'b1;
            end
            S_QX:
            begin
                ctl.op_a = z_reg;
                ctl.op_b = 32'(cfg.inv_focal_x);
            end
            S_QY:
            begin
                ctl.cap_qx = 1'b1;
                ctl.op_a   = z_reg;
                ctl.op_b   = 32'(cfg.inv_focal_y);
            end
            S_LOX:
            begin
                ctl.cap_qy = 1'b1;
                ctl.op_a   = 32'(mx_reg);
                ctl.op_b   = qx_reg[31:0];
            end
            S_HIX:
            begin
                ctl.cap_lo = 1'b1;
                ctl.op_a   = 32'(mx_reg);
                ctl.op_b   = 32'(qx_reg[55:32]);
            end
            S_LOY:
            begin
                ctl.cap_magx = 1'b1;
                ctl.op_a     = 32'(my_reg);
                ctl.op_b     = qy_reg[31:0];
            end
            S_HIY:
            begin
                ctl.cap_lo = 1'b1;
                ctl.op_a   = 32'(my_reg);
                ctl.op_b   = 32'(qy_reg[55:32]);
            end
            S_MAGY:
            begin
                ctl.cap_magy = 1'b1;
            end
            S_OUT:
            begin
                ctl.res_write = slot_free;
            end
            default:
            begin
                ctl = '0;
            end
        endcase
    end

    assign q_pop = ctl.load;

    // rounding of the captured products
    always_comb
    begin
        z_next   = 32'((prod_reg + 64'h8000) >> 16);
        lo_next  = LO_W'((prod_reg + 64'h100_0000) >> 25);
        mag_next = MAG_W'((prod_reg << 7) + 64'(lo_reg));
    end

    // result handshake
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (ctl.res_write)
            res_valid_next = 1'b1;
        else if (pop)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // shared multiplier and datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg <= ctl.op_a * ctl.op_b;
        if (ctl.load)
        begin
            depth_reg <= q_depth;
            blue_reg  <= q_blue;
            green_reg <= q_green;
            red_reg   <= q_red;
            col_reg   <= 12'(q_col);
            row_reg   <= 12'(q_row);
            negx_reg  <= dx[D_W-1];
            negy_reg  <= dy[D_W-1];
            mx_reg    <= dx_abs[M_W-1:0];
            my_reg    <= dy_abs[M_W-1:0];
        end
        if (ctl.cap_z)
            z_reg <= z_next;
        if (ctl.cap_qx)
            qx_reg <= prod_reg[55:0];
        if (ctl.cap_qy)
            qy_reg <= prod_reg[55:0];
        if (ctl.cap_lo)
            lo_reg <= lo_next;
        if (ctl.cap_magx)
            magx_reg <= mag_next;
        if (ctl.cap_magy)
            magy_reg <= mag_next;
        if (ctl.res_write)
        begin
            res_x_reg     <= sat_lateral(negx_reg, magx_reg);
            res_y_reg     <= sat_lateral(negy_reg, magy_reg);
            res_z_reg     <= z_reg;
            res_blue_reg  <= blue_reg;
            res_green_reg <= green_reg;
            res_red_reg   <= red_reg;
            res_col_reg   <= col_reg;
            res_row_reg   <= row_reg;
        end
    end

    // result ports
    assign empty       = !res_valid_reg;
    assign point_x     = $signed(res_x_reg);
    assign point_y     = $signed(res_y_reg);
    assign point_z     = res_z_reg;
    assign point_blue  = res_blue_reg;
    assign point_green = res_green_reg;
    assign point_red   = res_red_reg;
    assign point_col   = res_col_reg;
    assign point_row   = res_row_reg;

    `DPB_ASSERT_NEXT(a_back_result_written, clk, rst_n, state_reg == S_OUT && slot_free, res_valid_reg && state_reg == S_IDLE, "result not written on exit")
    `DPB_ASSERT_NEXT(a_back_result_kept, clk, rst_n, res_valid_reg && !pop, res_valid_reg, "waiting result lost")

endmodule

// ===== sv/depth_pixel_to_point_backprojection.sv =====
// path: a transaction with nonzero depth goes through the queue, the sequencer steps S_Z to S_OUT
// and the result register; the sequencer holds in S_OUT while the result register is occupied and not popped
// pacing: one point at a time, paced by the seven products of the shared 32x32 multiplier;
// zero-depth pixels skip the queue, yet are taken only while the 4-entry queue has room
// reset: rst_n is asynchronous, active low; it clears the pixel counters, the queue and the
// sequencer, and loads the default camera registers
module depth_pixel_to_point_backprojection import dpb_pkg::*; #(
    parameter int COORD_BITS = 12
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               push,
    output logic               full,
    input  logic [15:0]        depth_raw,
    input  logic [7:0]         blue,
    input  logic [7:0]         green,
    input  logic [7:0]         red,
    output logic               empty,
    input  logic               pop,
    output logic signed [31:0] point_x,
    output logic signed [31:0] point_y,
    output logic [31:0]        point_z,
    output logic [7:0]         point_blue,
    output logic [7:0]         point_green,
    output logic [7:0]         point_red,
    output logic [11:0]        point_col,
    output logic [11:0]        point_row
);

    localparam int ENTRY_W = 40 + 2 * COORD_BITS;

    cfg_t               cfg_reg;
    cfg_t               cfg_next;
    reg_idx_t           reg_idx;
    logic               cfg_write;
    logic               fifo_full;
    logic               fifo_push;
    logic [ENTRY_W-1:0] fifo_wdata;
    logic [ENTRY_W-1:0] fifo_rdata;
    logic               fifo_valid;
    logic               fifo_pop;

    // register access decode
    assign pready    = 1'b1;
    assign reg_idx   = paddr[ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (reg_idx)
                REG_FRAME_WIDTH:     cfg_next.frame_width     = pwdata[12:0];
                REG_FRAME_HEIGHT:    cfg_next.frame_height    = pwdata[12:0];
                REG_CENTER_X_HALF:   cfg_next.center_x_half   = pwdata[12:0];
                REG_CENTER_Y_HALF:   cfg_next.center_y_half   = pwdata[12:0];
                REG_INV_FOCAL_X:     cfg_next.inv_focal_x     = pwdata[23:0];
                REG_INV_FOCAL_Y:     cfg_next.inv_focal_y     = pwdata[23:0];
                REG_INV_DEPTH_SCALE: cfg_next.inv_depth_scale = pwdata;
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    // register read back
    always_comb
    begin
        unique case (reg_idx)
            REG_FRAME_WIDTH:     prdata = 32'(cfg_reg.frame_width);
            REG_FRAME_HEIGHT:    prdata = 32'(cfg_reg.frame_height);
            REG_CENTER_X_HALF:   prdata = 32'(cfg_reg.center_x_half);
            REG_CENTER_Y_HALF:   prdata = 32'(cfg_reg.center_y_half);
            REG_INV_FOCAL_X:     prdata = 32'(cfg_reg.inv_focal_x);
            REG_INV_FOCAL_Y:     prdata = 32'(cfg_reg.inv_focal_y);
            REG_INV_DEPTH_SCALE: prdata = cfg_reg.inv_depth_scale;
            default:             prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width     <= RST_FRAME_WIDTH;
            cfg_reg.frame_height    <= RST_FRAME_HEIGHT;
            cfg_reg.center_x_half   <= RST_CENTER_X_HALF;
            cfg_reg.center_y_half   <= RST_CENTER_Y_HALF;
            cfg_reg.inv_focal_x     <= RST_INV_FOCAL_X;
            cfg_reg.inv_focal_y     <= RST_INV_FOCAL_Y;
            cfg_reg.inv_depth_scale <= RST_INV_DEPTH_SCALE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // pixel intake and classification
    dpb_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .push      (push),
        .full      (full),
        .depth_raw (depth_raw),
        .blue      (blue),
        .green     (green),
        .red       (red),
        .fifo_full (fifo_full),
        .fifo_push (fifo_push),
        .fifo_data (fifo_wdata)
    );

    // queue between front and back end
    dpb_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fifo_push),
        .push_data (fifo_wdata),
        .full      (fifo_full),
        .pop       (fifo_pop),
        .pop_data  (fifo_rdata),
        .valid     (fifo_valid)
    );

    // point computation
    dpb_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_valid     (fifo_valid),
        .q_data      (fifo_rdata),
        .q_pop       (fifo_pop),
        .empty       (empty),
        .pop         (pop),
        .point_x     (point_x),
        .point_y     (point_y),
        .point_z     (point_z),
        .point_blue  (point_blue),
        .point_green (point_green),
        .point_red   (point_red),
        .point_col   (point_col),
        .point_row   (point_row)
    );

endmodule
